>>> rtl/pss_pkg.sv
`default_nettype none

package pss_pkg;

   localparam int UNITS_W = 10;
   localparam int SLOT_W  = 5;
   localparam int PHASE_W = 4;
   localparam int QUEUE_DEPTH = 2;

   // command codes on req_command
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_REGISTER   = 3'd1;
   localparam logic [2:0] CMD_UNREGISTER = 3'd2;
   localparam logic [2:0] CMD_BURST      = 3'd3;
   localparam logic [2:0] CMD_RELAX      = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_FIRE    = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_ACK     = 2'd2;

   // sleep reasons
   localparam logic [1:0] REASON_NEXT_CALL = 2'd0;
   localparam logic [1:0] REASON_ALIGN     = 2'd1;
   localparam logic [1:0] REASON_IDLE      = 2'd2;

   localparam logic [0:0] STATUS_OK       = 1'b0;
   localparam logic [0:0] STATUS_REJECTED = 1'b1;

   localparam logic [UNITS_W-1:0] SLEEP_MAX = 10'd1000;
   localparam logic [UNITS_W-1:0] PHASE_MOD = 10'd10;

   // reciprocal of 10 scaled by 2^16, rounded down
   localparam logic [12:0] RECIP_TEN = 13'd6553;
   localparam int          RECIP_SHIFT = 16;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_REGISTER,
      OP_UNREGISTER,
      OP_BURST,
      OP_RELAX,
      OP_REJECT
   } op_code_type;

   typedef struct packed {
      op_code_type        code;
      logic [SLOT_W-1:0]  slot;
      logic [UNITS_W-1:0] relax_units;
      logic [UNITS_W-1:0] burst_units;
      logic               has_init;
      logic [UNITS_W-1:0] elapsed;
   } op_type;

   typedef struct packed {
      logic [UNITS_W-1:0] relax;
      logic [UNITS_W-1:0] burst;
   } pair_type;

endpackage

`default_nettype wire

>>> rtl/pss_front.sv
`default_nettype none

module pss_front import pss_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [2:0]         req_command,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [UNITS_W-1:0] req_relax_units,
   input  wire logic [UNITS_W-1:0] req_burst_units,
   input  wire logic               req_has_init,
   input  wire logic [UNITS_W-1:0] req_elapsed,
   output logic                    push,
   output op_type                  op
);

   logic slot_ok;

   assign push    = start && !busy;
   assign slot_ok = 7'(req_slot) < 7'(SLOTS);

   always_comb begin
      op.slot         = req_slot;
      op.relax_units  = req_relax_units;
      op.burst_units  = req_burst_units;
      op.has_init     = req_has_init;
      op.elapsed      = req_elapsed;
      op.code         = OP_REJECT;
      if (req_command == CMD_TICK) begin
         op.code = OP_TICK;
      end else if (slot_ok) begin
         unique case (req_command)
            CMD_REGISTER: begin
               op.code = (req_relax_units == '0) ? OP_REJECT : OP_REGISTER;
            end
            CMD_UNREGISTER: op.code = OP_UNREGISTER;
            CMD_BURST:      op.code = OP_BURST;
            CMD_RELAX:      op.code = OP_RELAX;
            default:        op.code = OP_REJECT;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/pss_queue.sv
`default_nettype none

module pss_queue import pss_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   input  wire logic   pop,
   output op_type      head,
   output logic        empty,
   output logic        full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/pss_engine.sv
`default_nettype none

module pss_engine import pss_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire op_type              q_head,
   output logic                     q_pop,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_kind,
   output logic [SLOT_W-1:0]        rsp_fire_slot,
   output logic                     rsp_fire_init,
   output logic                     rsp_fire_main,
   output logic [UNITS_W-1:0]       rsp_rest_units,
   output logic [1:0]               rsp_rest_cause,
   output logic                     rsp_status,
   output logic                     rsp_last
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMD_RD,
      S_CMD,
      S_PHASE,
      S_ALIGN,
      S_WALK,
      S_SUM
   } state_type;

   state_type              state_ff;
   op_type                 cur_ff;
   logic [IDX_W-1:0]       walk_ff;
   logic [PHASE_W-1:0]     phase_ff;
   logic [6:0]             quot_ff;
   logic [UNITS_W-1:0]     sleep_ff;
   logic [1:0]             reason_ff;
   logic                   any_ff;

   logic [SLOTS-1:0]       registered_ff;
   logic [SLOTS-1:0]       aligned_ff;
   logic [SLOTS-1:0]       bursting_ff;
   logic [SLOTS-1:0]       init_ff;
   logic [SLOTS-1:0]       period_valid_ff;
   logic [SLOTS-1:0]       left_valid_ff;

   pair_type               period_mem [SLOTS];
   pair_type               left_mem   [SLOTS];
   pair_type               rd_period_ff;
   pair_type               rd_left_ff;

   logic                   rsp_strobe_ff;
   logic [1:0]             rsp_kind_ff;
   logic [SLOT_W-1:0]      rsp_fire_slot_ff;
   logic                   rsp_fire_init_ff;
   logic                   rsp_fire_main_ff;
   logic [UNITS_W-1:0]     rsp_rest_units_ff;
   logic [1:0]             rsp_rest_cause_ff;
   logic                   rsp_status_ff;
   logic                   rsp_last_ff;

   logic [IDX_W-1:0]       cur_idx;
   logic [IDX_W-1:0]       sel_idx;
   logic [IDX_W-1:0]       rd_addr;
   logic                   s_reg;
   logic                   s_aligned;
   logic                   s_burst;
   logic                   s_init;
   pair_type               per;
   pair_type               lft;
   logic [UNITS_W-1:0]     passed;
   logic                   b_out;
   logic                   r_out;
   pair_type               left_new;
   logic [UNITS_W-1:0]     active;
   logic                   waiting_align;
   logic                   fire_init;
   logic                   fire_main;
   logic [UNITS_W-1:0]     need;
   logic [10:0]            phase_sum;
   logic [23:0]            recip_prod;
   logic [10:0]            rem;
   logic                   period_we;
   logic                   left_we;
   pair_type               period_wdata;

   assign cur_idx = IDX_W'(cur_ff.slot);
   assign sel_idx = (state_ff == S_WALK) ? walk_ff : cur_idx;
   assign q_pop   = (state_ff == S_IDLE) && !q_empty;
   assign passed  = cur_ff.elapsed;

   always_comb begin
      case (state_ff)
         S_ALIGN: rd_addr = '0;
         S_WALK:  rd_addr = (walk_ff == LAST_IDX) ? walk_ff : walk_ff + 1'b1;
         default: rd_addr = cur_idx;
      endcase
   end

   // slot view; unwritten storage reads as zero
   assign s_reg     = registered_ff[sel_idx];
   assign s_aligned = aligned_ff[sel_idx];
   assign s_burst   = bursting_ff[sel_idx];
   assign s_init    = init_ff[sel_idx];
   assign per       = period_valid_ff[sel_idx] ? rd_period_ff : '0;
   assign lft       = left_valid_ff[sel_idx] ? rd_left_ff : '0;

   assign b_out          = lft.burst <= passed;
   assign r_out          = lft.relax <= passed;
   assign left_new.burst = b_out ? per.burst : lft.burst - passed;
   assign left_new.relax = r_out ? per.relax : lft.relax - passed;
   assign active         = s_burst ? left_new.burst : left_new.relax;
   assign waiting_align  = !s_aligned && (phase_ff != '0);
   assign fire_init      = !s_aligned && s_init;
   assign fire_main      = !s_aligned || (s_burst ? b_out : r_out);
   assign need           = PHASE_MOD - UNITS_W'(phase_ff);

   // phase mod 10 by reciprocal, one correction step
   assign phase_sum  = 11'(phase_ff) + 11'(passed);
   assign recip_prod = 24'(phase_sum) * 24'(RECIP_TEN);
   assign rem        = phase_sum - 11'({quot_ff, 3'b000}) - 11'({quot_ff, 1'b0});

   assign period_we    = (state_ff == S_CMD) && (cur_ff.code == OP_REGISTER);
   assign period_wdata = '{relax: cur_ff.relax_units, burst: cur_ff.burst_units};
   assign left_we      = (state_ff == S_WALK) && s_reg && !waiting_align;

   always_ff @(posedge clock) begin
      if (period_we) period_mem[cur_idx] <= period_wdata;
      if (left_we)   left_mem[walk_ff]   <= left_new;
      rd_period_ff <= period_mem[rd_addr];
      rd_left_ff   <= left_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= '0;
         registered_ff   <= '0;
         aligned_ff      <= '0;
         bursting_ff     <= '0;
         init_ff         <= '0;
         period_valid_ff <= '0;
         left_valid_ff   <= '0;
         rsp_strobe_ff   <= 1'b0;
         walk_ff         <= '0;
         any_ff          <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  cur_ff <= q_head;
                  if (q_head.code == OP_TICK) begin
                     sleep_ff  <= SLEEP_MAX;
                     reason_ff <= REASON_NEXT_CALL;
                     any_ff    <= 1'b0;
                     state_ff  <= S_PHASE;
                  end else begin
                     state_ff <= S_CMD_RD;
                  end
               end
            end
            S_CMD_RD: begin
               state_ff <= S_CMD;
            end
            S_CMD: begin
               rsp_strobe_ff       <= 1'b1;
               rsp_kind_ff         <= KIND_ACK;
               rsp_fire_slot_ff    <= '0;
               rsp_fire_init_ff    <= 1'b0;
               rsp_fire_main_ff    <= 1'b0;
               rsp_rest_units_ff   <= '0;
               rsp_rest_cause_ff   <= REASON_NEXT_CALL;
               rsp_last_ff         <= 1'b1;
               rsp_status_ff       <= STATUS_OK;
               unique case (cur_ff.code)
                  OP_REGISTER: begin
                     registered_ff[cur_idx]   <= 1'b1;
                     aligned_ff[cur_idx]      <= 1'b0;
                     bursting_ff[cur_idx]     <= 1'b0;
                     init_ff[cur_idx]         <= cur_ff.has_init;
                     period_valid_ff[cur_idx] <= 1'b1;
                  end
                  OP_UNREGISTER: begin
                     registered_ff[cur_idx]   <= 1'b0;
                     aligned_ff[cur_idx]      <= 1'b0;
                     bursting_ff[cur_idx]     <= 1'b0;
                     init_ff[cur_idx]         <= 1'b0;
                     period_valid_ff[cur_idx] <= 1'b0;
                     left_valid_ff[cur_idx]   <= 1'b0;
                  end
                  OP_BURST: begin
                     if (per.burst == '0) begin
                        rsp_status_ff <= STATUS_REJECTED;
                     end else begin
                        bursting_ff[cur_idx] <= 1'b1;
                     end
                  end
                  OP_RELAX: begin
                     bursting_ff[cur_idx] <= 1'b0;
                  end
                  default: begin
                     rsp_status_ff <= STATUS_REJECTED;
                  end
               endcase
               state_ff <= S_IDLE;
            end
            S_PHASE: begin
               quot_ff  <= recip_prod[RECIP_SHIFT+6:RECIP_SHIFT];
               state_ff <= S_ALIGN;
            end
            S_ALIGN: begin
               phase_ff <= (rem >= 11'(PHASE_MOD)) ? PHASE_W'(rem - 11'(PHASE_MOD))
                                                   : PHASE_W'(rem);
               walk_ff  <= '0;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (s_reg) begin
                  any_ff <= 1'b1;
                  if (waiting_align) begin
                     if (need < sleep_ff) begin
                        sleep_ff  <= need;
                        reason_ff <= REASON_ALIGN;
                     end
                  end else begin
                     aligned_ff[walk_ff]    <= 1'b1;
                     left_valid_ff[walk_ff] <= 1'b1;
                     if (active < sleep_ff) begin
                        sleep_ff  <= active;
                        reason_ff <= REASON_NEXT_CALL;
                     end
                     if (fire_init || fire_main) begin
                        rsp_strobe_ff       <= 1'b1;
                        rsp_kind_ff         <= KIND_FIRE;
                        rsp_fire_slot_ff    <= SLOT_W'(walk_ff);
                        rsp_fire_init_ff    <= fire_init;
                        rsp_fire_main_ff    <= fire_main;
                        rsp_rest_units_ff   <= '0;
                        rsp_rest_cause_ff   <= REASON_NEXT_CALL;
                        rsp_status_ff       <= STATUS_OK;
                        rsp_last_ff         <= 1'b0;
                     end
                  end
               end
               if (walk_ff == LAST_IDX) begin
                  state_ff <= S_SUM;
               end else begin
                  walk_ff <= walk_ff + 1'b1;
               end
            end
            S_SUM: begin
               rsp_strobe_ff       <= 1'b1;
               rsp_kind_ff         <= KIND_SUMMARY;
               rsp_fire_slot_ff    <= '0;
               rsp_fire_init_ff    <= 1'b0;
               rsp_fire_main_ff    <= 1'b0;
               rsp_rest_units_ff   <= sleep_ff;
               rsp_rest_cause_ff   <= any_ff ? reason_ff : REASON_IDLE;
               rsp_status_ff       <= STATUS_OK;
               rsp_last_ff         <= 1'b1;
               state_ff            <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fire_slot    = rsp_fire_slot_ff;
   assign rsp_fire_init    = rsp_fire_init_ff;
   assign rsp_fire_main    = rsp_fire_main_ff;
   assign rsp_rest_units   = rsp_rest_units_ff;
   assign rsp_rest_cause   = rsp_rest_cause_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/periodic_slot_scheduler_core.sv
`default_nettype none

// Periodic slot scheduler. Commands enter on start while busy is low and are
// held in a two-entry queue, so up to two items can be taken while the
// engine works. Each result is shown for one cycle with rsp_strobe and must
// be taken then: the receiver cannot stall the block. A tick walks all
// SLOTS slots, one per cycle, through the slot memories; it emits one fire
// result per firing slot, in index order, then the summary with rsp_last set.
// Register, unregister, burst and relax each pass through a registered period
// read and give one acknowledge with rsp_last set.
// No clearing pass is needed after reset.

module periodic_slot_scheduler_core import pss_pkg::*; #(
   parameter int SLOTS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_command,
   input  wire logic [SLOT_W-1:0]  req_slot,
   input  wire logic [UNITS_W-1:0] req_relax_units,
   input  wire logic [UNITS_W-1:0] req_burst_units,
   input  wire logic               req_has_init,
   input  wire logic [UNITS_W-1:0] req_elapsed,
   // result channel
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_kind,
   output logic [SLOT_W-1:0]       rsp_fire_slot,
   output logic                    rsp_fire_init,
   output logic                    rsp_fire_main,
   output logic [UNITS_W-1:0]      rsp_rest_units,
   output logic [1:0]              rsp_rest_cause,
   output logic                    rsp_status,
   output logic                    rsp_last
);

   logic   push;
   op_type push_op;
   op_type head;
   logic   empty;
   logic   full;
   logic   pop;

   // busy only reflects queue fill, not engine activity
   assign busy = full;

   // front: accept and classify the item
   pss_front #(.SLOTS(SLOTS)) u_front (
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_relax_units  (req_relax_units),
      .req_burst_units  (req_burst_units),
      .req_has_init     (req_has_init),
      .req_elapsed      (req_elapsed),
      .push             (push),
      .op               (push_op)
   );

   // queue between front and engine
   pss_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   // back: slot state, tick walk and result generation
   pss_engine #(.SLOTS(SLOTS)) u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (empty),
      .q_head           (head),
      .q_pop            (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_fire_slot    (rsp_fire_slot),
      .rsp_fire_init    (rsp_fire_init),
      .rsp_fire_main    (rsp_fire_main),
      .rsp_rest_units   (rsp_rest_units),
      .rsp_rest_cause   (rsp_rest_cause),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

>>> tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int NUM_SLOTS        = 32;
   localparam int DIRECTED_ROWS    = 25;
   localparam int RANDOM_PER_PHASE = 135;

   // command codes the block must reject
   localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [2:0] CMD_SPARE_MID = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

   // one result as it shows on the rsp_ ports
   typedef struct packed {
      logic [1:0]         kind;
      logic [SLOT_W-1:0]  fire_slot;
      logic               fire_init;
      logic               fire_main;
      logic [UNITS_W-1:0] rest_units;
      logic [1:0]         rest_cause;
      logic               status;
      logic               last;
   } sched_rsp_type;

   // one item for the req_ ports; the pin_ fields carry a hand-written
   // result for rows of the directed table whose answer is obvious
   typedef struct packed {
      logic [2:0]         command;
      logic [SLOT_W-1:0]  slot;
      logic [UNITS_W-1:0] relax_units;
      logic [UNITS_W-1:0] burst_units;
      logic               has_init;
      logic [UNITS_W-1:0] elapsed;
      logic               pinned;
      logic [1:0]         pin_kind;
      logic [UNITS_W-1:0] pin_sleep;
      logic [1:0]         pin_reason;
      logic               pin_status;
   } sched_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   sched_cmd_type drv = '0;

   logic                rsp_strobe;
   logic [1:0]          rsp_kind;
   logic [SLOT_W-1:0]   rsp_fire_slot;
   logic                rsp_fire_init;
   logic                rsp_fire_main;
   logic [UNITS_W-1:0]  rsp_rest_units;
   logic [1:0]          rsp_rest_cause;
   logic                rsp_status;
   logic                rsp_last;

   // shadow copy of the scheduler state
   bit slot_on      [NUM_SLOTS];
   bit slot_aligned [NUM_SLOTS];
   bit slot_burst   [NUM_SLOTS];
   bit slot_init    [NUM_SLOTS];
   int relax_per    [NUM_SLOTS];
   int burst_per    [NUM_SLOTS];
   int relax_cnt    [NUM_SLOTS];
   int burst_cnt    [NUM_SLOTS];
   int phase_cnt;

   // results still owed by the block, oldest first
   sched_rsp_type due_results [$];

   int n_items, n_ticks, n_rejects, n_fires, n_checked, n_errors;

   periodic_slot_scheduler_core #(.SLOTS(NUM_SLOTS)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (drv.command),
      .req_slot         (drv.slot),
      .req_relax_units  (drv.relax_units),
      .req_burst_units  (drv.burst_units),
      .req_has_init     (drv.has_init),
      .req_elapsed      (drv.elapsed),
      .rsp_strobe       (rsp_strobe),
      .rsp_kind         (rsp_kind),
      .rsp_fire_slot    (rsp_fire_slot),
      .rsp_fire_init    (rsp_fire_init),
      .rsp_fire_main    (rsp_fire_main),
      .rsp_rest_units   (rsp_rest_units),
      .rsp_rest_cause   (rsp_rest_cause),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one item to the shadow state and queue the results it causes.
   // A tick walks the slots in index order: unaligned slots wait for phase 0,
   // aligned ones count down both periods and reload whatever ran out.
   task automatic schedule_step(input sched_cmd_type c);
      int            passed;
      int            b, r, need, sleep;
      logic [1:0]    reason;
      bit            any, fi, fm;
      logic          st;
      sched_rsp_type res;
      passed = c.elapsed;
      if (c.command == CMD_TICK) begin
         n_ticks++;
         phase_cnt = (phase_cnt + passed) % PHASE_MOD;
         sleep = SLEEP_MAX;
         reason = REASON_NEXT_CALL;
         any = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_on[i]) continue;
            any = 1'b1;
            fi = 1'b0;
            fm = 1'b0;
            if (!slot_aligned[i]) begin
               if (phase_cnt != 0) begin
                  // still waiting for the phase to wrap
                  need = PHASE_MOD - phase_cnt;
                  if (need < sleep) begin
                     sleep = need;
                     reason = REASON_ALIGN;
                  end
                  continue;
               end
               // first aligned tick: main always, init if asked for
               slot_aligned[i] = 1'b1;
               fi = slot_init[i];
               fm = 1'b1;
            end
            b = burst_cnt[i] - passed;
            r = relax_cnt[i] - passed;
            if (b <= 0 && slot_burst[i]) fm = 1'b1;
            if (r <= 0 && !slot_burst[i]) fm = 1'b1;
            if (b <= 0) b = burst_per[i];
            if (r <= 0) r = relax_per[i];
            burst_cnt[i] = b;
            relax_cnt[i] = r;
            if (slot_burst[i] && b < sleep) begin
               sleep = b;
               reason = REASON_NEXT_CALL;
            end else if (!slot_burst[i] && r < sleep) begin
               sleep = r;
               reason = REASON_NEXT_CALL;
            end
            if (fi || fm) begin
               res = '0;
               res.kind = KIND_FIRE;
               res.fire_slot = SLOT_W'(i);
               res.fire_init = fi;
               res.fire_main = fm;
               due_results.push_back(res);
            end
         end
         if (!any) reason = REASON_IDLE;
         res = '0;
         res.kind = KIND_SUMMARY;
         res.rest_units = UNITS_W'(sleep);
         res.rest_cause = reason;
         res.last = 1'b1;
         due_results.push_back(res);
      end else begin
         st = STATUS_OK;
         if (c.command > CMD_RELAX || c.slot >= NUM_SLOTS) begin
            st = STATUS_REJECTED;
         end else begin
            case (c.command)
               CMD_REGISTER: begin
                  // remaining counts survive a re-register
                  if (c.relax_units == 0) begin
                     st = STATUS_REJECTED;
                  end else begin
                     slot_on[c.slot] = 1'b1;
                     slot_aligned[c.slot] = 1'b0;
                     slot_burst[c.slot] = 1'b0;
                     slot_init[c.slot] = c.has_init;
                     relax_per[c.slot] = c.relax_units;
                     burst_per[c.slot] = c.burst_units;
                  end
               end
               CMD_UNREGISTER: begin
                  slot_on[c.slot] = 1'b0;
                  slot_aligned[c.slot] = 1'b0;
                  slot_burst[c.slot] = 1'b0;
                  slot_init[c.slot] = 1'b0;
                  relax_per[c.slot] = 0;
                  burst_per[c.slot] = 0;
                  relax_cnt[c.slot] = 0;
                  burst_cnt[c.slot] = 0;
               end
               CMD_BURST: begin
                  if (burst_per[c.slot] == 0) st = STATUS_REJECTED;
                  else slot_burst[c.slot] = 1'b1;
               end
               default: begin
                  slot_burst[c.slot] = 1'b0;
               end
            endcase
         end
         if (st == STATUS_REJECTED) n_rejects++;
         res = '0;
         res.kind = KIND_ACK;
         res.status = st;
         res.last = 1'b1;
         due_results.push_back(res);
      end
   endtask

   task automatic match_field(input string name, input int want, input int got);
      if (want != got) begin
         n_errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Both channels are sampled at the rising edge, before the block's own
   // updates land, so accept and strobe are seen as they stood in the cycle.
   always @(posedge clock) begin
      sched_rsp_type want, got;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_aligned[i] = 1'b0;
            slot_burst[i] = 1'b0;
            slot_init[i] = 1'b0;
            relax_per[i] = 0;
            burst_per[i] = 0;
            relax_cnt[i] = 0;
            burst_cnt[i] = 0;
         end
         phase_cnt = 0;
         due_results.delete();
      end else begin
         // predict first, so a same-cycle answer would still find its entry
         if (start && !busy) begin
            n_items++;
            schedule_step(drv);
            if (drv.pinned) begin
               // hand-written answer stands in for the predicted one
               want = due_results.pop_back();
               want = '0;
               want.kind = drv.pin_kind;
               want.rest_units = drv.pin_sleep;
               want.rest_cause = drv.pin_reason;
               want.status = drv.pin_status;
               want.last = 1'b1;
               due_results.push_back(want);
            end
         end
         if (rsp_strobe) begin
            got.kind = rsp_kind;
            got.fire_slot = rsp_fire_slot;
            got.fire_init = rsp_fire_init;
            got.fire_main = rsp_fire_main;
            got.rest_units = rsp_rest_units;
            got.rest_cause = rsp_rest_cause;
            got.status = rsp_status;
            got.last = rsp_last;
            if (due_results.size() == 0) begin
               n_errors++;
               $display("%0t ns: result with nothing expected, expected none, actual kind %0d",
                        $time, got.kind);
            end else begin
               want = due_results.pop_front();
               n_checked++;
               if (got.kind == KIND_FIRE) n_fires++;
               match_field("kind", want.kind, got.kind);
               match_field("fire_slot", want.fire_slot, got.fire_slot);
               match_field("fire_init", want.fire_init, got.fire_init);
               match_field("fire_main", want.fire_main, got.fire_main);
               match_field("rest_units", want.rest_units, got.rest_units);
               match_field("rest_cause", want.rest_cause, got.rest_cause);
               match_field("status", want.status, got.status);
               match_field("last", want.last, got.last);
            end
         end
      end
   end

   // Present one item and hold it until the block takes it.
   task automatic put_item(input sched_cmd_type c);
      drv <= c;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Sender gap after an item: each cycle idles with the given odds.
   task automatic idle_gap(input int pct);
      while ($urandom_range(99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   initial begin
      sched_cmd_type plan [DIRECTED_ROWS];
      sched_cmd_type pick;
      int sel, pct;

      // Directed table: idle ticks at both ends of the elapsed count, the
      // spare command codes, every rejection, register at the period extremes,
      // burst/relax on a slot that was never registered, alignment wait,
      // alignment at phase 0, re-register of an aligned slot, teardown.
      plan = '{
         '{CMD_TICK, 0, 0, 0, 0, 0, 1, KIND_SUMMARY, SLEEP_MAX, REASON_IDLE, STATUS_OK},
         '{CMD_TICK, 0, 0, 0, 0, 1023, 1, KIND_SUMMARY, SLEEP_MAX, REASON_IDLE,
           STATUS_OK},
         '{CMD_SPARE_LO, 0, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL,
           STATUS_REJECTED},
         '{CMD_SPARE_MID, 31, 1023, 1023, 1, 1023, 1, KIND_ACK, 0, REASON_NEXT_CALL,
           STATUS_REJECTED},
         '{CMD_SPARE_HI, 0, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL,
           STATUS_REJECTED},
         '{CMD_REGISTER, 0, 0, 5, 1, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL,
           STATUS_REJECTED},
         '{CMD_BURST, 3, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_REJECTED},
         '{CMD_RELAX, 3, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_REGISTER, 0, 1023, 1023, 1, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL,
           STATUS_OK},
         '{CMD_REGISTER, 31, 1, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_REGISTER, 15, 7, 2, 1, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_BURST, 31, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_REJECTED},
         '{CMD_BURST, 15, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_TICK, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0},
         '{CMD_TICK, 0, 0, 0, 0, 4, 0, 0, 0, 0, 0},
         '{CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
         '{CMD_TICK, 0, 0, 0, 0, 1023, 0, 0, 0, 0, 0},
         '{CMD_RELAX, 15, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
         '{CMD_REGISTER, 0, 1, 1023, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_TICK, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0},
         '{CMD_UNREGISTER, 0, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_UNREGISTER, 31, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_UNREGISTER, 15, 0, 0, 0, 0, 1, KIND_ACK, 0, REASON_NEXT_CALL, STATUS_OK},
         '{CMD_TICK, 0, 0, 0, 0, 10, 1, KIND_SUMMARY, SLEEP_MAX, REASON_IDLE, STATUS_OK}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k]) begin
         put_item(plan[k]);
         idle_gap(22);
      end

      // Random part in three pacing phases: light sender gaps, heavy gaps,
      // then back-to-back. Registers outnumber unregisters so the slot table
      // fills up and ticks walk many live slots.
      for (int ph = 0; ph < 3; ph++) begin
         pct = (ph == 0) ? 22 : (ph == 1) ? 59 : 0;
         repeat (RANDOM_PER_PHASE) begin
            sel = $urandom_range(99);
            pick = '0;
            // fields a command ignores still get random content
            pick.slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
            pick.has_init = 1'($urandom_range(1));
            pick.relax_units = UNITS_W'($urandom_range(1023));
            pick.burst_units = UNITS_W'($urandom_range(1023));
            pick.elapsed = UNITS_W'($urandom_range(1023));
            if (sel < 45) begin
               pick.command = CMD_TICK;
               // mostly short steps so counts run out often; now and then a jump
               if ($urandom_range(7) != 0) pick.elapsed = UNITS_W'($urandom_range(12));
            end else if (sel < 65) begin
               pick.command = CMD_REGISTER;
               sel = $urandom_range(19);
               if (sel == 0) pick.relax_units = '0;
               else if (sel > 2) pick.relax_units = UNITS_W'($urandom_range(30, 1));
               if ($urandom_range(3) == 0) pick.burst_units = '0;
               else if ($urandom_range(5) != 0) begin
                  pick.burst_units = UNITS_W'($urandom_range(12, 1));
               end
            end else if (sel < 73) begin
               pick.command = CMD_UNREGISTER;
            end else if (sel < 84) begin
               pick.command = CMD_BURST;
            end else if (sel < 96) begin
               pick.command = CMD_RELAX;
            end else begin
               pick.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
            end
            put_item(pick);
            idle_gap(pct);
         end
      end
      start <= 1'b0;

      // drain: mid-cycle polling keeps clear of the monitor's edge updates
      do @(negedge clock); while (due_results.size() != 0);
      // a tick walks every slot; give stray results time to show up
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (due_results.size() != 0) n_errors++;

      $display("covered %0d items: %0d ticks, %0d commands, %0d rejected",
               n_items, n_ticks, n_items - n_ticks, n_rejects);
      $display("checked %0d results including %0d slot fires, %0d mismatches",
               n_checked, n_fires, n_errors);
      if (n_errors == 0) begin
         $display("periodic_slot_scheduler_core regression: pass");
      end else begin
         $display("periodic_slot_scheduler_core regression: fail");
      end
      $finish;
   end

   // hard stop, far past the slowest legal run
   initial begin
      #2_000_000;
      $display("periodic_slot_scheduler_core regression: fail");
      $finish;
   end

endmodule

>>> sim.f
rtl/pss_pkg.sv
rtl/pss_front.sv
rtl/pss_queue.sv
rtl/pss_engine.sv
rtl/periodic_slot_scheduler_core.sv
tb/testbench.sv
